@@ hdl/spq_pkg.sv @@
// shared types and codes for the sorted priority queue
package spq_pkg;

  localparam int KEY_W    = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_PEEK = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

endpackage

@@ hdl/spq_ram.sv @@
// entry store: one write port, one read port with registered data
module spq_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/sorted_priority_queue_top.sv @@
// bounded min-priority queue kept as a sorted ring in one memory
// Channels: in_* takes one word per operation: in_tuser is the operation
//   (push, pop, peek), in_tdata carries the key and handle used by push.
//   out_* returns exactly one word per operation: in_tuser-style status on
//   out_tuser, smallest key/handle (pop, peek), fill count and empty flag.
// Entries sit in ascending key order in a ring; a pop just advances the head.
// A push runs an insertion step from the tail back: each step reads one
//   entry, compares it against the new key on a single comparator and either
//   moves it up one slot or writes the new entry; the push ends once every
//   held entry of larger key has moved up and the new entry is written.
//   Pop and peek read the head entry once; a refused or unused operation
//   goes straight to its result. The memory's single read port sets the pace.
// in_tready is high only while no operation is in progress, so the next word
//   is taken only after the result is loaded; that result can still wait
//   in the output register meanwhile.
// If the receiver stalls, the result holds and a second finished result
//   waits inside until the output register frees.
// Reset (rst_n low, synchronous) empties the queue at once; the memory
//   contents are not cleared and are never read before being written.
module sorted_priority_queue_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int HANDLE_BITS = 16,
  localparam int FW    = $clog2(QUEUE_DEPTH + 1),
  localparam int IN_W  = ((spq_pkg::KEY_W + HANDLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((spq_pkg::KEY_W + HANDLE_BITS + FW + 1 + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [IN_W-1:0]              in_tdata,   // key_in, handle_in
  input  logic [spq_pkg::OP_W-1:0]     in_tuser,   // operation
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [OUT_W-1:0]             out_tdata,  // key_out, handle_out, fill_count, is_empty
  output logic [spq_pkg::STATUS_W-1:0] out_tuser   // status
);

  import spq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int EW = KEY_W + HANDLE_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STEP = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
    return (a == AW'(QUEUE_DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(QUEUE_DEPTH - 1) : a - 1'b1;
  endfunction

  logic [2:0]             state_r, state_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [AW-1:0]          tail_r, tail_nxt;
  logic [FW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [FW-1:0]          left_r, left_nxt;
  op_t                    op_r, op_nxt;
  logic [KEY_W-1:0]       key_r, key_nxt;
  logic [HANDLE_BITS-1:0] hdl_r, hdl_nxt;
  logic [KEY_W-1:0]       res_key_r, res_key_nxt;
  logic [HANDLE_BITS-1:0] res_hdl_r, res_hdl_nxt;
  status_t                res_st_r, res_st_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]       out_key_r, out_key_nxt;
  logic [HANDLE_BITS-1:0] out_hdl_r, out_hdl_nxt;
  status_t                out_st_r, out_st_nxt;
  logic [FW-1:0]          out_fill_r, out_fill_nxt;
  logic                   out_empty_r, out_empty_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;
  logic [KEY_W-1:0]       rd_key;
  logic [HANDLE_BITS-1:0] rd_hdl;

  assign rd_key = ram_rdata[KEY_W-1:0];
  assign rd_hdl = ram_rdata[EW-1:KEY_W];

  spq_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = OUT_W'({out_empty_r, out_fill_r, out_hdl_r, out_key_r});

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    wp_nxt        = wp_r;
    left_nxt      = left_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    hdl_nxt       = hdl_r;
    res_key_nxt   = res_key_r;
    res_hdl_nxt   = res_hdl_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_key_nxt   = out_key_r;
    out_hdl_nxt   = out_hdl_r;
    out_st_nxt    = out_st_r;
    out_fill_nxt  = out_fill_r;
    out_empty_nxt = out_empty_r;
    ram_we        = 1'b0;
    ram_waddr     = wp_r;
    ram_wdata     = {hdl_r, key_r};
    ram_re        = 1'b0;
    ram_raddr     = ring_dec(wp_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          key_nxt     = in_tdata[KEY_W-1:0];
          hdl_nxt     = in_tdata[EW-1:KEY_W];
          res_key_nxt = '0;
          res_hdl_nxt = '0;
          res_st_nxt  = STATUS_OK;
          state_nxt   = S_DONE;
          case (in_tuser) inside
            OP_PUSH: begin
              if (count_r == FW'(QUEUE_DEPTH)) begin
                res_st_nxt = STATUS_FULL;
              end else begin
                wp_nxt    = tail_r;
                left_nxt  = count_r;
                state_nxt = S_STEP;
              end
            end
            OP_POP, OP_PEEK: begin
              if (count_r == '0) begin
                res_st_nxt = STATUS_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = head_r;
                state_nxt = S_HEAD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_STEP: begin
        if (left_r == '0) begin
          ram_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          tail_nxt  = ring_inc(tail_r);
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        ram_we = 1'b1;
        // strict compare keeps equal keys in push order
        if ($signed(key_r) < $signed(rd_key)) begin
          ram_wdata = ram_rdata;
          wp_nxt    = ring_dec(wp_r);
          left_nxt  = left_r - 1'b1;
          state_nxt = S_STEP;
        end else begin
          count_nxt = count_r + 1'b1;
          tail_nxt  = ring_inc(tail_r);
          state_nxt = S_DONE;
        end
      end
      S_HEAD: begin
        res_key_nxt = rd_key;
        res_hdl_nxt = rd_hdl;
        if (op_r == OP_POP) begin
          head_nxt  = ring_inc(head_r);
          count_nxt = count_r - 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_key_nxt   = res_key_r;
          out_hdl_nxt   = res_hdl_r;
          out_st_nxt    = res_st_r;
          out_fill_nxt  = count_r;
          out_empty_nxt = (count_r == '0);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wp_r        <= wp_nxt;
    left_r      <= left_nxt;
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    hdl_r       <= hdl_nxt;
    res_key_r   <= res_key_nxt;
    res_hdl_r   <= res_hdl_nxt;
    res_st_r    <= res_st_nxt;
    out_key_r   <= out_key_nxt;
    out_hdl_r   <= out_hdl_nxt;
    out_st_r    <= out_st_nxt;
    out_fill_r  <= out_fill_nxt;
    out_empty_r <= out_empty_nxt;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FW'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_full_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == STATUS_FULL) |-> (out_fill_r == FW'(QUEUE_DEPTH)))
    else $error("push refused while queue not full");

  a_empty_report: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == STATUS_EMPTY) |-> (out_empty_r && out_fill_r == '0))
    else $error("empty status with entries held");

  a_busy_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STEP || state_r == S_CMP) |=> $stable(head_r))
    else $error("head moved during an insertion");
`endif

endmodule
